// ===== sv/prefix_rolling_hash_mersenne61_core_defines.svh =====
// Assertion macros shared by the rolling hash core.
// Depends on nothing; included by the files that carry assertions.
`ifndef PREFIX_ROLLING_HASH_MERSENNE61_CORE_DEFINES_SVH
`define PREFIX_ROLLING_HASH_MERSENNE61_CORE_DEFINES_SVH

// General form with an explicit clock and active-low reset.
`define RHM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Short form for modules clocked by clk_i and reset by rst_ni.
`define RHM_ASSERT(lbl, prop, msg) `RHM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/rhm_pkg.sv =====
// Shared types and constants of the rolling hash core.
// Depends on nothing; imported by every module of the core.
package rhm_pkg;

  localparam int unsigned HASH_W = 61;
  localparam logic [HASH_W-1:0] MOD61 = {HASH_W{1'b1}};

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_APP_MUL1,
    ST_APP_MUL2,
    ST_QRY_MUL
  } state_e;

endpackage

// ===== sv/rhm_mulmod.sv =====
// Iterative multiplier modulo 2^61-1: one 32x32 partial product a cycle,
// then a three-step Mersenne reduction. Depends on rhm_pkg.
module rhm_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rhm_pkg::HASH_W-1:0] a_i,
  input  logic [rhm_pkg::HASH_W-1:0] b_i,
  output logic                      done_o,
  output logic [rhm_pkg::HASH_W-1:0] res_o
);
  import rhm_pkg::*;

  localparam int unsigned PROD_W = 2 * HASH_W;
  localparam logic [2:0] CNT_RED1 = 3'd4;
  localparam logic [2:0] CNT_RED2 = 3'd5;
  localparam logic [2:0] CNT_LAST = 3'd6;

  logic              active_q;
  logic [2:0]        cnt_q;
  logic [HASH_W-1:0] a_q, b_q;
  logic [PROD_W-1:0] acc_q;
  logic [HASH_W:0]   red_q;
  logic [HASH_W-1:0] res_q;
  logic              done_q;

  logic [31:0]       op_a, op_b;
  logic [63:0]       pp;
  logic [6:0]        shift;
  logic [PROD_W-1:0] term;
  logic [HASH_W:0]   red1, red2;
  logic [HASH_W-1:0] final_val;

  always_comb begin
    op_a  = cnt_q[1] ? {3'b000, a_q[HASH_W-1:32]} : a_q[31:0];
    op_b  = cnt_q[0] ? {3'b000, b_q[HASH_W-1:32]} : b_q[31:0];
    pp    = op_a * op_b;
    shift = (cnt_q[1] && cnt_q[0]) ? 7'd64 : ((cnt_q[1] || cnt_q[0]) ? 7'd32 : 7'd0);
    term  = PROD_W'(pp) << shift;
    red1  = {1'b0, acc_q[PROD_W-1:HASH_W]} + {1'b0, acc_q[HASH_W-1:0]};
    red2  = {{HASH_W{1'b0}}, red_q[HASH_W]} + {1'b0, red_q[HASH_W-1:0]};
    final_val = (red_q >= {1'b0, MOD61}) ? HASH_W'(red_q - {1'b0, MOD61})
                                         : red_q[HASH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= active_q && (cnt_q == CNT_LAST);
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        if (cnt_q == CNT_LAST) begin
          active_q <= 1'b0;
        end
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (active_q) begin
      if (cnt_q < CNT_RED1) begin
        acc_q <= acc_q + term;
      end else if (cnt_q == CNT_RED1) begin
        red_q <= red1;
      end else if (cnt_q == CNT_RED2) begin
        red_q <= red2;
      end else begin
        res_q <= final_val;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/rhm_store.sv =====
// Prefix-hash and power memories with registered reads; entry zero reads
// as its fixed value. Depends on rhm_pkg.
module rhm_store #(
  parameter int unsigned DEPTH  = 1025,
  parameter int unsigned ADDR_W = 11
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [ADDR_W-1:0]          rd_a_addr_i,
  input  logic [ADDR_W-1:0]          rd_b_addr_i,
  input  logic [ADDR_W-1:0]          rd_p_addr_i,
  output logic [rhm_pkg::HASH_W-1:0] rd_a_data_o,
  output logic [rhm_pkg::HASH_W-1:0] rd_b_data_o,
  output logic [rhm_pkg::HASH_W-1:0] rd_p_data_o,
  input  logic                       wr_en_i,
  input  logic [ADDR_W-1:0]          wr_addr_i,
  input  logic [rhm_pkg::HASH_W-1:0] wr_prefix_i,
  input  logic [rhm_pkg::HASH_W-1:0] wr_power_i
);
  import rhm_pkg::*;

  logic [HASH_W-1:0] prefix_mem [DEPTH];
  logic [HASH_W-1:0] power_mem  [DEPTH];

  logic [HASH_W-1:0] a_q, b_q, p_q;
  logic              a_zero_q, b_zero_q, p_zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prefix_mem[wr_addr_i] <= wr_prefix_i;
      power_mem[wr_addr_i]  <= wr_power_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      a_q      <= prefix_mem[rd_a_addr_i];
      b_q      <= prefix_mem[rd_b_addr_i];
      p_q      <= power_mem[rd_p_addr_i];
      a_zero_q <= (rd_a_addr_i == '0);
      b_zero_q <= (rd_b_addr_i == '0);
      p_zero_q <= (rd_p_addr_i == '0);
    end
  end

  assign rd_a_data_o = a_zero_q ? '0 : a_q;
  assign rd_b_data_o = b_zero_q ? '0 : b_q;
  assign rd_p_data_o = p_zero_q ? HASH_W'(1) : p_q;

endmodule

// ===== sv/prefix_rolling_hash_mersenne61_core.sv =====
// Top level of the polynomial rolling hash core modulo 2^61-1.
// Depends on rhm_pkg, rhm_store, rhm_mulmod and the assertion header.
//
// An item is taken when start is high and busy is low, and each item gives
// one result on the result ports, marked by done_o for one cycle; the
// receiver cannot stall it. A query runs one product through the shared
// modular multiplier and an append two in series, both after a registered
// memory read. Clear items, unused modes, invalid ranges and appends to a
// full sequence finish without leaving the idle state. The memories need
// no clearing pass after reset.
`include "prefix_rolling_hash_mersenne61_core_defines.svh"

module prefix_rolling_hash_mersenne61_core #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rhm_pkg::HASH_W-1:0] cfg_wdata_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode_i,
  input  logic [rhm_pkg::HASH_W-1:0] value_i,
  input  logic [LEN_W-1:0]           left_i,
  input  logic [LEN_W-1:0]           right_i,
  output logic                       done_o,
  output logic [rhm_pkg::HASH_W-1:0] hash_value_o,
  output logic [1:0]                 status_o,
  output logic [LEN_W-1:0]           length_o
);
  import rhm_pkg::*;

  localparam int unsigned DEPTH = MAX_LEN + 1;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LEN);
  localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(37);

  function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, MOD61}) ? HASH_W'(s - {1'b0, MOD61}) : s[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, MOD61 - b};
    return (s >= {1'b0, MOD61}) ? HASH_W'(s - {1'b0, MOD61}) : s[HASH_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [HASH_W-1:0] base_q;
  logic [1:0]        mode_q;
  logic [HASH_W-1:0] value_q;
  logic [HASH_W-1:0] hold_q, hold_d;
  logic              done_q, done_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [1:0]        status_q, status_d;
  logic [LEN_W-1:0]  length_q, length_d;

  logic              accept, full, range_ok, launch;
  logic              rd_en, wr_en;
  logic [LEN_W-1:0]  rd_a_addr, rd_b_addr, rd_p_addr, wr_addr;
  logic [HASH_W-1:0] rd_a_data, rd_b_data, rd_p_data;
  logic              mul_start, mul_done;
  logic [HASH_W-1:0] mul_a, mul_b, mul_res;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_q == FULL_LEN);
  assign range_ok = (left_i <= right_i) && (right_i <= count_q);
  assign launch   = accept && (((mode_i == MODE_APPEND) && !full) ||
                               ((mode_i == MODE_QUERY) && range_ok));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (launch) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = (mode_q == MODE_APPEND) ? ST_APP_MUL1 : ST_QRY_MUL;
      end
      ST_APP_MUL1: begin
        if (mul_done) begin
          state_d = ST_APP_MUL2;
        end
      end
      ST_APP_MUL2, ST_QRY_MUL: begin
        if (mul_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_a_addr = count_q;
    rd_b_addr = left_i;
    rd_p_addr = count_q;
    wr_en     = 1'b0;
    wr_addr   = count_q + LEN_W'(1);
    mul_start = 1'b0;
    mul_a     = rd_a_data;
    mul_b     = base_q;
    hold_d    = hold_q;
    count_d   = count_q;
    done_d    = 1'b0;
    hash_d    = '0;
    status_d  = STATUS_OK;
    length_d  = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_APPEND: begin
              if (full) begin
                done_d   = 1'b1;
                status_d = STATUS_FULL;
              end else begin
                rd_en = 1'b1;
              end
            end
            MODE_QUERY: begin
              if (range_ok) begin
                rd_en     = 1'b1;
                rd_a_addr = right_i;
                rd_p_addr = right_i - left_i;
              end else begin
                done_d   = 1'b1;
                status_d = STATUS_RANGE;
              end
            end
            MODE_CLEAR: begin
              done_d   = 1'b1;
              count_d  = '0;
              length_d = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        mul_start = 1'b1;
        if (mode_q != MODE_APPEND) begin
          mul_a  = rd_b_data;
          mul_b  = rd_p_data;
          hold_d = rd_a_data;
        end
      end
      ST_APP_MUL1: begin
        mul_a = rd_p_data;
        if (mul_done) begin
          hold_d    = add_mod(mul_res, value_q);
          mul_start = 1'b1;
        end
      end
      ST_APP_MUL2: begin
        if (mul_done) begin
          wr_en    = 1'b1;
          count_d  = wr_addr;
          done_d   = 1'b1;
          hash_d   = hold_q;
          length_d = wr_addr;
        end
      end
      ST_QRY_MUL: begin
        if (mul_done) begin
          done_d = 1'b1;
          hash_d = sub_mod(hold_q, mul_res);
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      base_q  <= BASE_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        base_q <= (cfg_wdata_i == MOD61) ? '0 : cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= (value_i == MOD61) ? '0 : value_i;
    end
    hold_q   <= hold_d;
    hash_q   <= hash_d;
    status_q <= status_d;
    length_q <= length_d;
  end

  rhm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (LEN_W)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_p_addr_i (rd_p_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data),
    .rd_p_data_o (rd_p_data),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_prefix_i (hold_q),
    .wr_power_i  (mul_res)
  );

  rhm_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  assign done_o       = done_q;
  assign hash_value_o = hash_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

  `RHM_ASSERT(a_write_not_full, wr_en |-> (count_q != FULL_LEN), "write past capacity")
  `RHM_ASSERT(a_count_with_result, (count_q != $past(count_q)) |-> done_o, "count moved silently")
  `RHM_ASSERT(a_full_length, (done_o && (status_o == STATUS_FULL)) |-> (length_o == FULL_LEN), "full flagged below capacity")
  `RHM_ASSERT(a_mul_done_expected, mul_done |-> ((state_q == ST_APP_MUL1) || (state_q == ST_APP_MUL2) || (state_q == ST_QRY_MUL)), "unexpected product")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the rolling hash core modulo 2^61-1.
// Depends on rhm_pkg and prefix_rolling_hash_mersenne61_core; an embedded tracker
// mirrors the prefix and power tables and checks every result item.
module tb_top;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef logic [rhm_pkg::HASH_W-1:0] hash_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    hash_t      hash;
    logic [1:0] status;
    len_t       length;
  } hash_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  hash_t      cfg_wdata_i = '0;
  logic       start       = 1'b0;
  logic       busy;
  logic [1:0] mode_i      = rhm_pkg::MODE_APPEND;
  hash_t      value_i     = '0;
  len_t       left_i      = '0;
  len_t       right_i     = '0;
  logic       done_o;
  hash_t      hash_value_o;
  logic [1:0] status_o;
  len_t       length_o;

  bit          burst;
  int unsigned stim_len;
  int unsigned base_writes;
  int unsigned cycle_count;

  class range_hash_tracker;
    hash_t        base_reg;
    hash_t        prefix_tab [0:DEPTH];
    hash_t        power_tab [0:DEPTH];
    int unsigned  held;
    hash_result_t awaited [$];
    int unsigned  mismatches, checked;
    int unsigned  n_append, n_full, n_query, n_range, n_clear, n_unused;

    function void init_state();
      prefix_tab[0] = '0;
      power_tab[0]  = hash_t'(1);
      held          = 0;
      base_reg      = hash_t'(37);
    endfunction

    function void set_base(hash_t v);
      base_reg = v;
    endfunction

    function hash_t fold_operand(hash_t x);
      return (x == rhm_pkg::MOD61) ? '0 : x;
    endfunction

    function hash_t mulmod61(hash_t a, hash_t b);
      logic [121:0] prod;
      logic [61:0]  acc;
      prod = {61'd0, a} * {61'd0, b};
      acc  = {1'b0, prod[60:0]} + {1'b0, prod[121:61]};
      acc  = {1'b0, acc[60:0]} + {61'd0, acc[61]};
      if (acc >= {1'b0, rhm_pkg::MOD61}) acc = acc - {1'b0, rhm_pkg::MOD61};
      return acc[60:0];
    endfunction

    function hash_t addmod61(hash_t a, hash_t b);
      logic [61:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, rhm_pkg::MOD61}) s = s - {1'b0, rhm_pkg::MOD61};
      return s[60:0];
    endfunction

    function hash_t submod61(hash_t a, hash_t b);
      logic [61:0] s;
      s = {1'b0, a} + {1'b0, rhm_pkg::MOD61 - b};
      if (s >= {1'b0, rhm_pkg::MOD61}) s = s - {1'b0, rhm_pkg::MOD61};
      return s[60:0];
    endfunction

    function void record_item(logic [1:0] mode, hash_t value, len_t left, len_t right);
      hash_result_t r;
      hash_t        b;
      hash_t        v;
      r        = '0;
      r.status = rhm_pkg::STATUS_OK;
      v        = fold_operand(value);
      case (mode)
        rhm_pkg::MODE_APPEND: begin
          n_append++;
          if (held >= DEPTH) begin
            r.status = rhm_pkg::STATUS_FULL;
            n_full++;
          end else begin
            b                   = fold_operand(base_reg);
            r.hash              = addmod61(mulmod61(prefix_tab[held], b), v);
            power_tab[held + 1]  = mulmod61(power_tab[held], b);
            prefix_tab[held + 1] = r.hash;
            held++;
          end
        end
        rhm_pkg::MODE_QUERY: begin
          n_query++;
          if (left <= right && right <= held) begin
            r.hash = submod61(prefix_tab[right],
                              mulmod61(prefix_tab[left], power_tab[right - left]));
          end else begin
            r.status = rhm_pkg::STATUS_RANGE;
            n_range++;
          end
        end
        rhm_pkg::MODE_CLEAR: begin
          n_clear++;
          held = 0;
        end
        default: begin
          n_unused++;
        end
      endcase
      r.length = len_t'(held);
      awaited.insert(awaited.size(), r);
    endfunction

    function void compare_result(hash_t hash, logic [1:0] status, len_t length);
      hash_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result item: hash %h status %0d length %0d",
                   hash, status, length);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.hash !== hash || want.status !== status || want.length !== length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on item %0d: expected hash %h status %0d length %0d, got hash %h status %0d length %0d",
                   checked, want.hash, want.status, want.length, hash, status, length);
      end
    endfunction
  endclass

  range_hash_tracker tracker;

  prefix_rolling_hash_mersenne61_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .left_i      (left_i),
    .right_i     (right_i),
    .done_o      (done_o),
    .hash_value_o(hash_value_o),
    .status_o    (status_o),
    .length_o    (length_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Configuration writes, accepted items and result items are all observed in one
  // process, so their order within an edge is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.set_base(cfg_wdata_i);
      if (start && !busy) tracker.record_item(mode_i, value_i, left_i, right_i);
      if (done_o) tracker.compare_result(hash_value_o, status_o, length_o);
    end
  end

  function automatic hash_t rand_hash();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[60:0];
  endfunction

  function automatic hash_t pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return rhm_pkg::MOD61;
      2:       return rhm_pkg::MOD61 - hash_t'(1);
      3:       return hash_t'(1);
      default: return rand_hash();
    endcase
  endfunction

  function automatic len_t rand_len();
    return len_t'($urandom_range(0, 2047));
  endfunction

  task automatic send_item(input logic [1:0] mode, input hash_t value,
                           input len_t left, input len_t right);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    mode_i  <= mode;
    value_i <= value;
    left_i  <= left;
    right_i <= right;
    do @(posedge clk_i); while (busy);
    if (mode == rhm_pkg::MODE_APPEND && stim_len < DEPTH) stim_len++;
    if (mode == rhm_pkg::MODE_CLEAR) stim_len = 0;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.awaited.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base(input hash_t v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    base_writes++;
  endtask

  task automatic run_directed();
    burst = 1'b0;
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd0, 11'd0);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd0, 11'd1);
    send_item(rhm_pkg::MODE_APPEND, '0, '0, '0);
    send_item(rhm_pkg::MODE_APPEND, rhm_pkg::MOD61, '0, '0);
    send_item(rhm_pkg::MODE_APPEND, rhm_pkg::MOD61 - hash_t'(1), '0, '0);
    send_item(rhm_pkg::MODE_APPEND, hash_t'(1), '0, '0);
    send_item(rhm_pkg::MODE_APPEND, rand_hash(), '1, '1);
    send_item(rhm_pkg::MODE_QUERY, '1, 11'd0, 11'd5);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd2, 11'd4);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd3, 11'd3);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd5, 11'd5);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd4, 11'd2);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd0, 11'd6);
    send_item(rhm_pkg::MODE_QUERY, '0, '1, '1);
    send_item(MODE_UNUSED, '1, '1, '1);
    send_item(rhm_pkg::MODE_CLEAR, rand_hash(), rand_len(), rand_len());
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd0, 11'd0);
    send_item(rhm_pkg::MODE_APPEND, rand_hash(), '0, '0);
    send_item(rhm_pkg::MODE_QUERY, rand_hash(), 11'd0, 11'd1);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd1, 11'd1);
  endtask

  task automatic run_mix(input int unsigned n);
    int unsigned k, pick, r_idx, l_idx;
    for (k = 0; k < n; k++) begin
      if (k % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_item(rhm_pkg::MODE_APPEND, pick_value(), rand_len(), rand_len());
      end else if (pick < 84) begin
        r_idx = $urandom_range(0, stim_len);
        l_idx = $urandom_range(0, r_idx);
        if ($urandom_range(0, 7) == 0) begin
          r_idx = stim_len;
          l_idx = 0;
        end
        send_item(rhm_pkg::MODE_QUERY, rand_hash(), len_t'(l_idx), len_t'(r_idx));
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0: begin
            r_idx = stim_len + 1 + $urandom_range(0, 2046 - stim_len);
            l_idx = $urandom_range(0, r_idx);
          end
          1: begin
            r_idx = $urandom_range(0, 2046);
            l_idx = $urandom_range(r_idx + 1, 2047);
          end
          default: begin
            r_idx = $urandom_range(0, 2047);
            l_idx = $urandom_range(0, 2047);
          end
        endcase
        send_item(rhm_pkg::MODE_QUERY, rand_hash(), len_t'(l_idx), len_t'(r_idx));
      end else if (pick < 94) begin
        send_item(rhm_pkg::MODE_CLEAR, rand_hash(), rand_len(), rand_len());
      end else begin
        send_item(MODE_UNUSED, rand_hash(), rand_len(), rand_len());
      end
    end
  endtask

  task automatic fill_sequence();
    int unsigned i, r_idx;
    burst = 1'b0;
    send_item(rhm_pkg::MODE_CLEAR, '0, '0, '0);
    for (i = 0; i < DEPTH; i++) begin
      if (i % 32 == 0) burst = ($urandom_range(0, 1) == 0);
      send_item(rhm_pkg::MODE_APPEND, pick_value(), rand_len(), rand_len());
      if (i % 64 == 63) begin
        r_idx = $urandom_range(0, stim_len);
        send_item(rhm_pkg::MODE_QUERY, '0, len_t'($urandom_range(0, r_idx)), len_t'(r_idx));
      end
    end
    repeat (3) send_item(rhm_pkg::MODE_APPEND, rand_hash(), '0, '0);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd0, 11'd1024);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd1024, 11'd1024);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd1023, 11'd1024);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd512, 11'd1024);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd1000, 11'd1025);
    send_item(rhm_pkg::MODE_QUERY, '0, 11'd1025, 11'd1024);
    send_item(rhm_pkg::MODE_CLEAR, '1, '1, '1);
  endtask

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    tracker = new;
    tracker.init_state();
    stim_len    = 0;
    base_writes = 0;
    burst       = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    write_base(rhm_pkg::MOD61);
    run_mix(110);
    write_base('0);
    run_mix(110);
    write_base(hash_t'(1));
    run_mix(110);
    write_base(rhm_pkg::MOD61 - hash_t'(1));
    run_mix(110);
    write_base(rand_hash());
    fill_sequence();
    write_base(rand_hash());
    run_mix(110);
    write_base(hash_t'(37));
    run_mix(110);

    wait_drained();
    $display("Covered %0d appends (%0d on a full sequence), %0d queries (%0d bad ranges), %0d clears and %0d unused items.",
             tracker.n_append, tracker.n_full, tracker.n_query, tracker.n_range,
             tracker.n_clear, tracker.n_unused);
    $display("Checked %0d result items over %0d base writes: %0d mismatches, %0d still awaited.",
             tracker.checked, base_writes, tracker.mismatches, tracker.awaited.size());
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
